FILE: sv/pse_pkg.sv
// shared types and constants of the packed symmetric equilibration block
// no dependencies
`default_nettype none

package pse_pkg;

	localparam int MAX_ORDER = 64;
	localparam int POS_W     = $clog2(MAX_ORDER);
	localparam int ORDER_W   = POS_W + 1;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [16:0] RATIO_THRESHOLD = 17'd6554;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_ELEM  = 2'd2;

	localparam logic [1:0] REG_ORDER        = 2'd0;
	localparam logic [1:0] REG_UPPER_STORED = 2'd1;
	localparam logic [1:0] REG_MAG_LOW      = 2'd2;
	localparam logic [1:0] REG_MAG_HIGH     = 2'd3;

	localparam logic        KIND_START = 1'b0;
	localparam logic        KIND_ELEM  = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_ELEM  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [5:0]  index;
		logic [31:0] scale_factor;
		logic [16:0] ratio;
		logic [31:0] largest_magnitude;
		logic signed [31:0] element;
	} pse_in_t;

	typedef struct packed {
		logic        kind;
		logic        equilibrated;
		logic signed [31:0] scaled_element;
		logic        saturated;
		logic        last_element;
	} pse_out_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] addr_a;
		logic [POS_W-1:0] addr_b;
		logic [31:0]      data;
		logic             equil;
		logic             last;
	} cmd_t;

endpackage

`default_nettype wire

FILE: sv/pse_front.sv
// front end: configuration registers, start decision and packed triangle walk
// depends on pse_pkg
`default_nettype none

module pse_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_write,
	input  wire [1:0]            cfg_index,
	input  wire [31:0]           cfg_data,
	input  wire                  take,
	input  pse_pkg::pse_in_t     in_item,
	output logic                 cmd_push,
	output pse_pkg::cmd_t        cmd
);
	import pse_pkg::*;

	logic [ORDER_W-1:0] order_q;
	logic               upper_q;
	logic [31:0]        low_q;
	logic [31:0]        high_q;
	logic [POS_W-1:0]   row_q;
	logic [POS_W-1:0]   col_q;
	logic               scaling_q;

	logic [ORDER_W-1:0] n;
	logic [ORDER_W-1:0] n_m1;
	logic [POS_W-1:0]   r;
	logic [POS_W-1:0]   c;
	logic [POS_W-1:0]   row_d;
	logic [POS_W-1:0]   col_d;
	logic               scaling_d;
	logic               skip;
	logic               outside;
	logic               last;

	assign n = (order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_q;
	assign n_m1 = n - ORDER_W'(1);

	assign skip = (in_item.ratio >= RATIO_THRESHOLD)
		&& (in_item.largest_magnitude >= low_q)
		&& (in_item.largest_magnitude <= high_q);

	always_comb begin
		if (upper_q) begin
			outside = ({1'b0, col_q} >= n) || (row_q > col_q);
		end else begin
			outside = ({1'b0, col_q} >= n) || (row_q < col_q) || ({1'b0, row_q} >= n);
		end
		r = outside ? '0 : row_q;
		c = outside ? '0 : col_q;
		last = ({1'b0, r} == n_m1) && ({1'b0, c} == n_m1);
	end

	always_comb begin
		row_d     = row_q;
		col_d     = col_q;
		scaling_d = scaling_q;
		cmd_push  = 1'b0;
		cmd.op     = OP_LOAD;
		cmd.addr_a = in_item.index[POS_W-1:0];
		cmd.addr_b = '0;
		cmd.data   = in_item.scale_factor;
		cmd.equil  = 1'b0;
		cmd.last   = 1'b0;
		if (take) begin
			unique case (in_item.func)
				FUNC_LOAD: begin
					cmd_push = 1'b1;
				end
				FUNC_START: begin
					cmd_push  = 1'b1;
					scaling_d = (n != '0) && !skip;
					row_d     = '0;
					col_d     = '0;
					cmd.op    = OP_START;
					cmd.equil = scaling_d;
				end
				FUNC_ELEM: begin
					cmd_push   = 1'b1;
					cmd.op     = OP_ELEM;
					cmd.data   = in_item.element;
					cmd.addr_a = r;
					cmd.addr_b = c;
					if (n == '0) begin
						row_d     = '0;
						col_d     = '0;
						cmd.equil = 1'b0;
						cmd.last  = 1'b1;
					end else begin
						cmd.equil = scaling_q;
						cmd.last  = last;
						if (last) begin
							row_d = '0;
							col_d = '0;
						end else if (upper_q) begin
							if (r == c) begin
								col_d = c + POS_W'(1);
								row_d = '0;
							end else begin
								row_d = r + POS_W'(1);
								col_d = c;
							end
						end else begin
							if ({1'b0, r} == n_m1) begin
								col_d = c + POS_W'(1);
								row_d = c + POS_W'(1);
							end else begin
								row_d = r + POS_W'(1);
								col_d = c;
							end
						end
					end
				end
				default: begin
					cmd_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q   <= '0;
			upper_q   <= 1'b1;
			low_q     <= 32'd1;
			high_q    <= 32'hFFFF_FFFF;
			row_q     <= '0;
			col_q     <= '0;
			scaling_q <= 1'b0;
		end else begin
			row_q     <= row_d;
			col_q     <= col_d;
			scaling_q <= scaling_d;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_ORDER:        order_q <= cfg_data[ORDER_W-1:0];
					REG_UPPER_STORED: upper_q <= cfg_data[0];
					REG_MAG_LOW:      low_q   <= cfg_data;
					REG_MAG_HIGH:     high_q  <= cfg_data;
					default:          order_q <= order_q;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/pse_queue.sv
// short command queue between the front end and the arithmetic back end
// depends on pse_pkg
`default_nettype none

module pse_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr,
	input  pse_pkg::cmd_t  wr_cmd,
	output logic           full,
	input  wire            rd,
	output logic           valid,
	output pse_pkg::cmd_t  rd_cmd
);
	import pse_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_cmd = slot_q[rd_ptr_q];
	assign do_wr  = wr && !full;
	assign do_rd  = rd && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: sv/pse_back.sv
// back end: scale store, scale product, rounding, saturation and result register
// depends on pse_pkg
`default_nettype none

module pse_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	input  pse_pkg::cmd_t      cmd,
	output logic               cmd_take,
	output logic               empty,
	input  wire                pop,
	output pse_pkg::pse_out_t  out_item
);
	import pse_pkg::*;

	logic [31:0] store_q [MAX_ORDER];

	logic        v_s1, v_s2, v_s3, v_s4, out_valid_q;
	cmd_t        cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [31:0] sa_s1, sb_s1;
	logic [63:0] p_s2;
	logic [31:0] m_s2;
	logic [63:0] lo_s3, hi_s3;
	logic [63:0] sum_s4;
	pse_out_t    out_q;

	logic        en;
	logic [31:0] m_d;
	logic [47:0] mag;
	logic        neg;
	pse_out_t    res;

	assign en       = !out_valid_q || pop;
	assign cmd_take = cmd_valid && en;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	assign m_d = cmd_s1.data[31] ? (~cmd_s1.data + 32'd1) : cmd_s1.data;

	always_comb begin
		neg = cmd_s4.data[31];
		mag = sum_s4[63:16] + {47'd0, sum_s4[15]};
		res.kind           = KIND_ELEM;
		res.equilibrated   = cmd_s4.equil;
		res.scaled_element = cmd_s4.data;
		res.saturated      = 1'b0;
		res.last_element   = cmd_s4.last;
		if (cmd_s4.op == OP_START) begin
			res.kind           = KIND_START;
			res.scaled_element = '0;
			res.last_element   = 1'b0;
		end else if (cmd_s4.equil) begin
			if (!neg) begin
				if (mag > 48'h7FFF_FFFF) begin
					res.saturated      = 1'b1;
					res.scaled_element = 32'h7FFF_FFFF;
				end else begin
					res.scaled_element = mag[31:0];
				end
			end else begin
				if (mag > 48'h8000_0000) begin
					res.saturated      = 1'b1;
					res.scaled_element = 32'h8000_0000;
				end else begin
					res.scaled_element = 32'd0 - mag[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= cmd_take && (cmd.op != OP_LOAD);
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			if (cmd.op == OP_LOAD) begin
				store_q[cmd.addr_a] <= cmd.data;
			end else begin
				sa_s1 <= store_q[cmd.addr_a];
				sb_s1 <= store_q[cmd.addr_b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
			p_s2   <= {32'd0, sa_s1} * {32'd0, sb_s1};
			m_s2   <= m_d;
			cmd_s3 <= cmd_s2;
			lo_s3  <= {32'd0, p_s2[31:0]} * {32'd0, m_s2};
			hi_s3  <= {32'd0, p_s2[63:32]} * {32'd0, m_s2};
			cmd_s4 <= cmd_s3;
			sum_s4 <= hi_s3 + {32'd0, lo_s3[63:32]};
			out_q  <= res;
		end
	end

endmodule

`default_nettype wire

FILE: sv/packed_symmetric_equilibration.sv
// packed symmetric equilibration: front end, command queue and arithmetic back end
// items go through the command queue and the five-stage scale and round pipeline
// throughput: one item per cycle while the result register is empty or popped
// reset: walk position, scaling flag, queue and pipeline cleared; registers to defaults
// the scale store is not cleared and holds unknown values until loaded
`default_nettype none

module packed_symmetric_equilibration (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_write,
	input  wire [1:0]          cfg_index,
	input  wire [31:0]         cfg_data,
	input  wire                push,
	output logic               full,
	input  pse_pkg::pse_in_t   in_item,
	output logic               empty,
	input  wire                pop,
	output pse_pkg::pse_out_t  out_item
);
	import pse_pkg::*;

	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_valid;
	logic cmd_take;
	logic take;

	assign take = push && !full;

	pse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.in_item   (in_item),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	pse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wr_cmd (cmd_in),
		.full   (full),
		.rd     (cmd_take),
		.valid  (cmd_valid),
		.rd_cmd (cmd_out)
	);

	pse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
